// ----- sv/bsp_pkg.sv -----
`timescale 1ns / 1ps
// bsp_pkg: shared constants, node and control types for the BSP point locator.
// No dependencies.
package bsp_pkg;

    localparam int NODE_COUNT = 1024;
    localparam int MAX_STEPS  = 64;

    localparam int ADDR_W  = $clog2(NODE_COUNT);
    localparam int STEP_W  = $clog2(MAX_STEPS + 1);
    // signed width of a child address: node address plus 16-bit offset
    localparam int CADDR_W = ((ADDR_W > 16) ? ADDR_W : 16) + 2;

    localparam logic signed [CADDR_W-1:0] NODE_LIMIT = CADDR_W'(NODE_COUNT);

    localparam int NORM_W = 16;
    localparam int PT_W   = 32;
    localparam int PROD_W = NORM_W + PT_W;
    localparam int SUM_W  = PROD_W + 3;
    localparam int DIST_SHIFT = 14;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic [1:0] REG_EMPTY_CODE = 2'd0;
    localparam logic [1:0] REG_SOLID_CODE = 2'd1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_LIMIT = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [NORM_W-1:0] normal_z;
        logic [NORM_W-1:0] normal_y;
        logic [NORM_W-1:0] normal_x;
        logic [31:0]       dist_word;
        logic [15:0]       back;
        logic [15:0]       front;
    } t_node;

    localparam int NODE_W = $bits(t_node);

    typedef struct packed {
        logic mul_en;
        logic sum_en;
    } t_dot_ctrl;

endpackage

// ----- sv/bsp_node_ram.sv -----
`timescale 1ns / 1ps
// bsp_node_ram: single-port-write, single-port-read synchronous RAM with registered read data.
// No dependencies.
module bsp_node_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- sv/bsp_plane_dot.sv -----
`timescale 1ns / 1ps
// bsp_plane_dot: two-stage plane side test, dot(normal, point) - dist * 2^14 >= 0.
// Depends on bsp_pkg.
module bsp_plane_dot (
    input  logic                        i_clk,
    input  bsp_pkg::t_dot_ctrl          i_ctrl,
    input  bsp_pkg::t_node              i_node,
    input  logic signed [bsp_pkg::PT_W-1:0] i_px,
    input  logic signed [bsp_pkg::PT_W-1:0] i_py,
    input  logic signed [bsp_pkg::PT_W-1:0] i_pz,
    output logic                        o_front
);

    logic signed [bsp_pkg::PROD_W-1:0] r_prod_x;
    logic signed [bsp_pkg::PROD_W-1:0] r_prod_y;
    logic signed [bsp_pkg::PROD_W-1:0] r_prod_z;
    logic signed [31:0]                r_dist;
    logic                              r_front;
    logic signed [bsp_pkg::SUM_W-1:0]  acc;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod_x <= bsp_pkg::PROD_W'(signed'(i_node.normal_x) * i_px);
            r_prod_y <= bsp_pkg::PROD_W'(signed'(i_node.normal_y) * i_py);
            r_prod_z <= bsp_pkg::PROD_W'(signed'(i_node.normal_z) * i_pz);
            r_dist   <= signed'(i_node.dist_word);
        end
    end

    always_comb begin
        acc = bsp_pkg::SUM_W'(r_prod_x) + bsp_pkg::SUM_W'(r_prod_y)
            + bsp_pkg::SUM_W'(r_prod_z)
            - (bsp_pkg::SUM_W'(r_dist) <<< bsp_pkg::DIST_SHIFT);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.sum_en) begin
            r_front <= ~acc[bsp_pkg::SUM_W-1];
        end
    end

    assign o_front = r_front;

endmodule

// ----- sv/bsp_point_location.sv -----
`timescale 1ns / 1ps
// bsp_point_location: top level, walk sequencer around the node RAM and plane test.
// Depends on bsp_pkg, bsp_node_ram, bsp_plane_dot.
//
// A write item loads one node in the cycle it is taken and gives no result; the
// block stays free. A query item holds busy while it walks: a first node read,
// then per descent the states S_EVAL, S_ACC and S_SEL (node RAM read feeding the
// registered multipliers, the 51-bit plane sum, child select and the next RAM
// read). The walk ends on a leaf, at the 64-step limit, or when the start node
// or a child address falls outside node memory. The result is on the outputs
// for one cycle only, marked by o_result_valid; the receiver cannot stall it,
// and a new item may be started in that same cycle.
module bsp_point_location (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_action,
    input  logic [9:0]         i_node_addr,
    input  logic signed [15:0] i_normal_x,
    input  logic signed [15:0] i_normal_y,
    input  logic signed [15:0] i_normal_z,
    input  logic signed [31:0] i_plane_dist,
    input  logic signed [15:0] i_child_front,
    input  logic signed [15:0] i_child_back,
    input  logic [9:0]         i_start_node,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_point_z,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    output logic               o_result_valid,
    output logic signed [15:0] o_leaf_code,
    output logic               o_empty_leaf,
    output logic signed [31:0] o_leaf_index,
    output logic [1:0]         o_status
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_ACC  = 2'd2;
    localparam logic [1:0] S_SEL  = 2'd3;

    localparam int AW = bsp_pkg::ADDR_W;
    localparam int CW = bsp_pkg::CADDR_W;
    localparam int SW = bsp_pkg::STEP_W;

    logic [1:0]           r_state, n_state;
    logic [AW-1:0]        r_cur, n_cur;
    logic [SW-1:0]        r_steps, n_steps;
    logic                 r_start_oob, n_start_oob;
    logic signed [15:0]   r_empty_code, r_solid_code;
    logic signed [31:0]   r_px, r_py, r_pz;
    logic signed [15:0]   r_off_f, r_off_b, n_off_f, n_off_b;
    logic signed [CW-1:0] r_next_f, r_next_b, n_next_f, n_next_b;

    logic                 r_res_valid, n_res_valid;
    logic signed [15:0]   r_leaf_code, n_leaf_code;
    logic                 r_empty_leaf, n_empty_leaf;
    logic signed [31:0]   r_leaf_index, n_leaf_index;
    logic [1:0]           r_status, n_status;

    logic                 accept, wr_en, rd_en;
    logic [AW-1:0]        rd_addr;
    logic signed [CW-1:0] wr_pos, start_pos, cur_pos, nxt;
    bsp_pkg::t_node       wr_node, rd_node;
    bsp_pkg::t_dot_ctrl   dot_ctrl;
    logic                 dot_front;
    logic signed [15:0]   code;
    logic                 internal;

    assign accept    = start && !busy;
    assign wr_pos    = signed'(CW'(i_node_addr));
    assign start_pos = signed'(CW'(i_start_node));
    assign cur_pos   = signed'(CW'(r_cur));
    assign wr_en     = accept && (i_action == bsp_pkg::ACT_WRITE) &&
                       (wr_pos < bsp_pkg::NODE_LIMIT);

    always_comb begin
        wr_node.normal_x  = i_normal_x;
        wr_node.normal_y  = i_normal_y;
        wr_node.normal_z  = i_normal_z;
        wr_node.dist_word = i_plane_dist;
        wr_node.front     = i_child_front;
        wr_node.back      = i_child_back;
    end

    bsp_node_ram #(
        .DATA_W (bsp_pkg::NODE_W),
        .DEPTH  (bsp_pkg::NODE_COUNT),
        .ADDR_W (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (AW'(i_node_addr)),
        .i_wr_data (wr_node),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_node)
    );

    bsp_plane_dot u_dot (
        .i_clk   (i_clk),
        .i_ctrl  (dot_ctrl),
        .i_node  (rd_node),
        .i_px    (r_px),
        .i_py    (r_py),
        .i_pz    (r_pz),
        .o_front (dot_front)
    );

    assign code     = signed'(rd_node.front);
    assign internal = (code > r_empty_code) && (code < r_solid_code);
    assign nxt      = dot_front ? r_next_f : r_next_b;

    always_comb begin
        n_state      = r_state;
        n_cur        = r_cur;
        n_steps      = r_steps;
        n_start_oob  = r_start_oob;
        n_off_f      = r_off_f;
        n_off_b      = r_off_b;
        n_next_f     = r_next_f;
        n_next_b     = r_next_b;
        n_res_valid  = 1'b0;
        n_leaf_code  = r_leaf_code;
        n_empty_leaf = r_empty_leaf;
        n_leaf_index = r_leaf_index;
        n_status     = r_status;
        rd_en        = 1'b0;
        rd_addr      = AW'(i_start_node);
        dot_ctrl     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_action == bsp_pkg::ACT_QUERY)) begin
                    rd_en       = 1'b1;
                    n_cur       = AW'(i_start_node);
                    n_steps     = '0;
                    n_start_oob = !(start_pos < bsp_pkg::NODE_LIMIT);
                    n_state     = S_EVAL;
                end
            end
            S_EVAL: begin
                if (r_start_oob) begin
                    n_res_valid  = 1'b1;
                    n_leaf_code  = '0;
                    n_empty_leaf = 1'b0;
                    n_leaf_index = '0;
                    n_status     = bsp_pkg::ST_RANGE;
                    n_state      = S_IDLE;
                end else if (!internal) begin
                    n_res_valid  = 1'b1;
                    n_leaf_code  = code;
                    n_empty_leaf = (code == r_empty_code);
                    n_leaf_index = (code == r_empty_code) ? signed'(rd_node.dist_word) : '0;
                    n_status     = bsp_pkg::ST_OK;
                    n_state      = S_IDLE;
                end else if (r_steps == SW'(bsp_pkg::MAX_STEPS)) begin
                    n_res_valid  = 1'b1;
                    n_leaf_code  = '0;
                    n_empty_leaf = 1'b0;
                    n_leaf_index = '0;
                    n_status     = bsp_pkg::ST_LIMIT;
                    n_state      = S_IDLE;
                end else begin
                    dot_ctrl.mul_en = 1'b1;
                    n_off_f         = code;
                    n_off_b         = signed'(rd_node.back);
                    n_steps         = r_steps + SW'(1);
                    n_state         = S_ACC;
                end
            end
            S_ACC: begin
                dot_ctrl.sum_en = 1'b1;
                n_next_f        = cur_pos + CW'(r_off_f);
                n_next_b        = cur_pos + CW'(r_off_b);
                n_state         = S_SEL;
            end
            S_SEL: begin
                if (nxt < 0 || !(nxt < bsp_pkg::NODE_LIMIT)) begin
                    n_res_valid  = 1'b1;
                    n_leaf_code  = '0;
                    n_empty_leaf = 1'b0;
                    n_leaf_index = '0;
                    n_status     = bsp_pkg::ST_RANGE;
                    n_state      = S_IDLE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(nxt);
                    n_cur   = AW'(nxt);
                    n_state = S_EVAL;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_res_valid  <= 1'b0;
            r_empty_code <= -16'sd1;
            r_solid_code <= 16'sd32767;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
            if (i_cfg_we && (i_cfg_idx == bsp_pkg::REG_EMPTY_CODE)) begin
                r_empty_code <= signed'(i_cfg_data);
            end
            if (i_cfg_we && (i_cfg_idx == bsp_pkg::REG_SOLID_CODE)) begin
                r_solid_code <= signed'(i_cfg_data);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur        <= n_cur;
        r_steps      <= n_steps;
        r_start_oob  <= n_start_oob;
        r_off_f      <= n_off_f;
        r_off_b      <= n_off_b;
        r_next_f     <= n_next_f;
        r_next_b     <= n_next_b;
        r_leaf_code  <= n_leaf_code;
        r_empty_leaf <= n_empty_leaf;
        r_leaf_index <= n_leaf_index;
        r_status     <= n_status;
        if (accept && (i_action == bsp_pkg::ACT_QUERY)) begin
            r_px <= i_point_x;
            r_py <= i_point_y;
            r_pz <= i_point_z;
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_res_valid;
    assign o_leaf_code    = r_leaf_code;
    assign o_empty_leaf   = r_empty_leaf;
    assign o_leaf_index   = r_leaf_index;
    assign o_status       = r_status;

endmodule

// ----- sv/bsp_chk.sv -----
`timescale 1ns / 1ps
// bsp_chk: port-level checks for bsp_point_location, bound to the top level.
// Depends on bsp_pkg and bsp_point_location.
module bsp_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               i_action,
    input logic               o_result_valid,
    input logic signed [15:0] o_leaf_code,
    input logic               o_empty_leaf,
    input logic signed [31:0] o_leaf_index,
    input logic [1:0]         o_status
);

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_status == bsp_pkg::ST_OK || o_status == bsp_pkg::ST_LIMIT ||
                            o_status == bsp_pkg::ST_RANGE))
        else $error("undefined status code");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status != bsp_pkg::ST_OK) |->
        (o_leaf_code == 16'sd0 && !o_empty_leaf && o_leaf_index == 32'sd0))
        else $error("failed walk reports nonzero leaf fields");

    a_solid_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status == bsp_pkg::ST_OK && !o_empty_leaf) |->
        (o_leaf_index == 32'sd0))
        else $error("non-empty leaf with nonzero index");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_action == bsp_pkg::ACT_QUERY) |=> busy)
        else $error("query item taken without going busy");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (!busy ##1 !o_result_valid))
        else $error("result strobe while busy or held two cycles");

endmodule

bind bsp_point_location bsp_chk u_bsp_chk (.*);
